// ----- rtl/core/nbd_pkg.sv -----
// shared types and constants for the base-255 digit converter
`timescale 1ns / 1ps

package nbd_pkg;

   localparam int BYTE_W     = 8;
   localparam int FULL_BYTES = 16;
   localparam int IDX_W      = 4;
   localparam int COUNT_W    = 5;
   localparam logic [BYTE_W-1:0] RADIX = 8'hFF;

   // one pass of the division travelling from a cell to its lower neighbor
   typedef struct packed {
      logic              valid;
      logic              nz;
      logic [BYTE_W-1:0] rem;
   } link_type;

   typedef struct packed {
      logic [63:0]        digits_low;
      logic [63:0]        digits_high;
      logic [BYTE_W-1:0]  extra_digit;
      logic [COUNT_W-1:0] digit_count;
   } result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/core/nbd_cell.sv -----
// one byte cell of the division chain: divides rem:byte by 255 per pass
`timescale 1ns / 1ps

module nbd_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic [7:0]          load_num,
   input  nbd_pkg::link_type   link_in,
   output nbd_pkg::link_type   link_out
);

   logic [7:0]        num_ff;
   logic [7:0]        num_in;
   nbd_pkg::link_type link_ff;
   nbd_pkg::link_type link_in_next;
   logic [8:0]        sum;
   logic              wrap;

   // rem*256 + b = rem*255 + (rem + b), and rem + b stays below 2*255
   always_comb begin
      sum  = {1'b0, link_in.rem} + {1'b0, num_ff};
      wrap = (sum >= {1'b0, nbd_pkg::RADIX});
      num_in = num_ff;
      link_in_next.valid = 1'b0;
      link_in_next.nz    = link_in.nz | (num_ff != 8'd0);
      link_in_next.rem   = wrap ? 8'(sum - {1'b0, nbd_pkg::RADIX}) : sum[7:0];
      if (load) begin
         num_in = load_num;
      end else if (link_in.valid) begin
         num_in = link_in.rem + {7'd0, wrap};
         link_in_next.valid = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      num_ff       <= num_in;
      link_ff.nz   <= link_in_next.nz;
      link_ff.rem  <= link_in_next.rem;
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else begin
         link_ff.valid <= link_in_next.valid;
      end
   end

   assign link_out = link_ff;

endmodule

// ----- rtl/core/nbd_collect.sv -----
// gathers remainders leaving the bottom cell into packed digit bytes
`timescale 1ns / 1ps

module nbd_collect #(
   parameter int NUM_BYTES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  nbd_pkg::link_type    link_in,
   output logic                 last,
   output nbd_pkg::result_type  result
);

   localparam logic [nbd_pkg::COUNT_W-1:0] NB = nbd_pkg::COUNT_W'(NUM_BYTES);

   logic [nbd_pkg::FULL_BYTES-1:0][7:0] dig_ff;
   logic [7:0]                          extra_ff;
   logic [nbd_pkg::COUNT_W-1:0]         count_ff;
   logic [nbd_pkg::COUNT_W-1:0]         rx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_ff    <= '0;
         count_ff <= '0;
         extra_ff <= '0;
         dig_ff   <= '0;
      end else if (clear) begin
         rx_ff    <= '0;
         count_ff <= '0;
         extra_ff <= '0;
         dig_ff   <= '0;
      end else if (link_in.valid) begin
         rx_ff <= rx_ff + nbd_pkg::COUNT_W'(1);
         // a digit exists only while the number before this pass was nonzero
         if (link_in.nz) begin
            if (count_ff < NB) begin
               dig_ff[count_ff[nbd_pkg::IDX_W-1:0]] <= link_in.rem + 8'd1;
            end else begin
               extra_ff <= link_in.rem + 8'd1;
            end
            count_ff <= count_ff + nbd_pkg::COUNT_W'(1);
         end
      end
   end

   assign last = link_in.valid && (rx_ff == NB);

   assign result.digits_low  = dig_ff[7:0];
   assign result.digits_high = dig_ff[15:8];
   assign result.extra_digit = extra_ff;
   assign result.digit_count = count_ff;

endmodule

// ----- rtl/core/number_to_base255_digits.sv -----
// top level: base-255 digit converter built as a chain of byte cells
`timescale 1ns / 1ps

// Converts a NUM_BYTES-byte unsigned number into base-255 digits (each remainder
// plus one, least significant first). Every cell holds one byte and runs one
// division pass per cycle; passes enter the top cell one per cycle and ripple
// down as a wavefront until all NUM_BYTES+1 passes have left the chain. One item
// is accepted at a time, and req_stall holds off the next one until the result
// has moved into an output register; the next item is then taken while that
// result waits. Input bytes above NUM_BYTES are ignored; digit_count is zero
// for a zero input. NUM_BYTES above 16 acts as 16 and below 1 acts as 1.
module number_to_base255_digits #(
   parameter int NUM_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_value_low,
   input  logic [63:0] req_value_high,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digits_low,
   output logic [63:0] rsp_digits_high,
   output logic [7:0]  rsp_extra_digit,
   output logic [4:0]  rsp_digit_count
);

   localparam int WIDTH = (NUM_BYTES > nbd_pkg::FULL_BYTES) ? nbd_pkg::FULL_BYTES :
                          ((NUM_BYTES < 1) ? 1 : NUM_BYTES);
   localparam logic [nbd_pkg::COUNT_W-1:0] NB = nbd_pkg::COUNT_W'(WIDTH);

   nbd_pkg::state_type          state_ff, state_in;
   logic [nbd_pkg::COUNT_W-1:0] cnt_ff, cnt_in;
   logic                        load;
   logic                        xfer;
   logic                        last;
   logic                        rsp_valid_ff, rsp_valid_in;
   nbd_pkg::result_type         result;
   nbd_pkg::result_type         rsp_ff;
   nbd_pkg::link_type           link [WIDTH:0];
   logic [127:0]                value;

   assign value = {req_value_high, req_value_low};

   // passes are issued at the top of the chain with an empty remainder
   assign link[WIDTH] = '{valid: (state_ff == nbd_pkg::ST_RUN) && (cnt_ff <= NB),
                          nz: 1'b0, rem: 8'd0};

   for (genvar i = 0; i < WIDTH; i++) begin : g_cell
      nbd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .load     (load),
         .load_num (value[8*i +: 8]),
         .link_in  (link[i+1]),
         .link_out (link[i])
      );
   end

   nbd_collect #(
      .NUM_BYTES (WIDTH)
   ) u_collect (
      .clock   (clock),
      .reset   (reset),
      .clear   (load),
      .link_in (link[0]),
      .last    (last),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nbd_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (xfer) begin
         rsp_ff <= result;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      load     = 1'b0;
      xfer     = 1'b0;
      unique case (state_ff)
         nbd_pkg::ST_IDLE: begin
            if (req_valid) begin
               load     = 1'b1;
               cnt_in   = '0;
               state_in = nbd_pkg::ST_RUN;
            end
         end
         nbd_pkg::ST_RUN: begin
            if (cnt_ff <= NB) begin
               cnt_in = cnt_ff + nbd_pkg::COUNT_W'(1);
            end
            if (last) begin
               state_in = nbd_pkg::ST_DONE;
            end
         end
         nbd_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               xfer     = 1'b1;
               state_in = nbd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nbd_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = xfer | (rsp_valid_ff & rsp_stall);
   end

   assign req_stall       = (state_ff != nbd_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digits_low  = rsp_ff.digits_low;
   assign rsp_digits_high = rsp_ff.digits_high;
   assign rsp_extra_digit = rsp_ff.extra_digit;
   assign rsp_digit_count = rsp_ff.digit_count;

`ifndef SYNTHESIS
   a_last_in_run: assert property (@(posedge clock) disable iff (reset)
      last |-> (state_ff == nbd_pkg::ST_RUN))
      else $error("final pass left the chain outside of a run");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_count <= NB + 5'd1))
      else $error("digit count beyond width plus one");

   a_zero_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_digit_count == 5'd0)) |->
         ((rsp_digits_low == 64'd0) && (rsp_digits_high == 64'd0)
          && (rsp_extra_digit == 8'd0)))
      else $error("digits present with a zero count");

   a_extra_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_extra_digit != 8'd0)) |-> (rsp_digit_count == NB + 5'd1))
      else $error("extra digit without a full digit count");
`endif

endmodule

// ----- tb/tb_number_to_base255_digits.sv -----
// testbench for the base-255 digit converter: directed table, then random items
`timescale 1ns / 1ps

module tb_number_to_base255_digits;

   localparam int WIDTH_BYTES = nbd_pkg::FULL_BYTES;
   localparam int LATENCY     = 2 * WIDTH_BYTES + 4;
   localparam int PHASE_ITEMS = 100;
   localparam longint TIMEOUT_NS = 64'd5_000_000;

   typedef struct {
      logic [63:0]         value_low;
      logic [63:0]         value_high;
      bit                  typed;
      nbd_pkg::result_type want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_value_low;
   logic [63:0] req_value_high;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_digits_low;
   logic [63:0] rsp_digits_high;
   logic [7:0]  rsp_extra_digit;
   logic [4:0]  rsp_digit_count;

   nbd_pkg::result_type pending_digits[$];
   int                  fail_count;
   int                  sender_idle_pct;
   int                  receiver_stall_pct;

   number_to_base255_digits #(
      .NUM_BYTES(WIDTH_BYTES)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value_low  (req_value_low),
      .req_value_high (req_value_high),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digits_low (rsp_digits_low),
      .rsp_digits_high(rsp_digits_high),
      .rsp_extra_digit(rsp_extra_digit),
      .rsp_digit_count(rsp_digit_count)
   );

   always #5 clock = ~clock;

   // repeated division by 255, each remainder plus one is a digit
   function automatic nbd_pkg::result_type base255_digits(logic [63:0] lo, logic [63:0] hi);
      logic [127:0]        quotient;
      logic [7:0]          digit;
      nbd_pkg::result_type r;
      int                  count;
      quotient = {hi, lo};
      if (WIDTH_BYTES < nbd_pkg::FULL_BYTES)
         quotient = quotient & ((128'd1 << (8 * WIDTH_BYTES)) - 128'd1);
      r = '0;
      count = 0;
      while (quotient != 128'd0 && count <= WIDTH_BYTES) begin
         digit = 8'(quotient % 128'(nbd_pkg::RADIX)) + 8'd1;
         quotient = quotient / 128'(nbd_pkg::RADIX);
         if (count >= WIDTH_BYTES)
            r.extra_digit = digit;
         else if (count < 8)
            r.digits_low[8*count +: 8] = digit;
         else
            r.digits_high[8*(count-8) +: 8] = digit;
         count++;
      end
      r.digit_count = nbd_pkg::COUNT_W'(count);
      return r;
   endfunction

   function automatic logic [127:0] pow255(int k);
      logic [127:0] p;
      p = 128'd1;
      for (int i = 0; i < k; i++)
         p = p * 128'd255;
      return p;
   endfunction

   function automatic logic [127:0] random_wide();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic logic [127:0] random_value();
      logic [127:0] v;
      int           pick;
      pick = $urandom_range(0, 4);
      v = random_wide();
      case (pick)
         0: begin
         end
         1: begin
            // numbers shifted right by a random amount, so of any width up to 128 bits
            v = v >> $urandom_range(0, 127);
         end
         2: begin
            v = pow255($urandom_range(0, WIDTH_BYTES)) + 128'($urandom_range(0, 4)) - 128'd2;
         end
         3: begin
            // large input: a seventeenth digit is needed
            v = pow255(WIDTH_BYTES) + (v >> 5);
         end
         default: begin
            for (int i = 0; i < 16; i++)
               case ($urandom_range(0, 2))
                  0: v[8*i +: 8] = 8'h00;
                  1: v[8*i +: 8] = 8'hFF;
                  default: begin
                  end
               endcase
         end
      endcase
      return v;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // expectation is recorded at the edge where the input item is taken
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         pending_digits.push_back(base255_digits(req_value_low, req_value_high));
   end

   always @(posedge clock) begin
      nbd_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_digits.size() == 0) begin
            $display("%0t: unexpected item: expected none, actual %h %h %h %h", $time,
                     rsp_digits_low, rsp_digits_high, rsp_extra_digit, rsp_digit_count);
            fail_count++;
         end else begin
            want = pending_digits.pop_front();
            check_field("digits_low", want.digits_low, rsp_digits_low);
            check_field("digits_high", want.digits_high, rsp_digits_high);
            check_field("extra_digit", 64'(want.extra_digit), 64'(rsp_extra_digit));
            check_field("digit_count", 64'(want.digit_count), 64'(rsp_digit_count));
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   task automatic send_value(logic [127:0] v);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_value_low  <= v[63:0];
      req_value_high <= v[127:64];
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // hold the sender off until every outstanding result has come back
   task automatic wait_all_returned();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_digits.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      stim_row_type        rows[$];
      nbd_pkg::result_type directed_want;
      logic [127:0]        top_value;
      top_value = pow255(WIDTH_BYTES);

      // hand-checked rows carry their result, the rest rely on the predictor
      rows.push_back('{64'd0, 64'd0, 1'b1, '{64'd0, 64'd0, 8'd0, 5'd0}});
      rows.push_back('{64'd1, 64'd0, 1'b1, '{64'h02, 64'd0, 8'd0, 5'd1}});
      rows.push_back('{64'd254, 64'd0, 1'b1, '{64'hFF, 64'd0, 8'd0, 5'd1}});
      rows.push_back('{64'd255, 64'd0, 1'b1, '{64'h0201, 64'd0, 8'd0, 5'd2}});
      rows.push_back('{64'd65024, 64'd0, 1'b1, '{64'hFFFF, 64'd0, 8'd0, 5'd2}});
      rows.push_back('{64'd65025, 64'd0, 1'b1, '{64'h020101, 64'd0, 8'd0, 5'd3}});
      rows.push_back('{64'(top_value - 128'd1), 64'((top_value - 128'd1) >> 64), 1'b1,
                       '{{8{8'hFF}}, {8{8'hFF}}, 8'd0, 5'd16}});
      rows.push_back('{64'(top_value), 64'(top_value >> 64), 1'b1,
                       '{{8{8'h01}}, {8{8'h01}}, 8'd2, 5'd17}});
      rows.push_back('{64'(top_value + 128'd1), 64'((top_value + 128'd1) >> 64), 1'b0,
                       '{64'd0, 64'd0, 8'd0, 5'd0}});
      rows.push_back('{'1, '1, 1'b0, '{64'd0, 64'd0, 8'd0, 5'd0}});
      rows.push_back('{'1, 64'd0, 1'b0, '{64'd0, 64'd0, 8'd0, 5'd0}});
      rows.push_back('{64'd0, '1, 1'b0, '{64'd0, 64'd0, 8'd0, 5'd0}});
      rows.push_back('{64'd0, 64'd1, 1'b0, '{64'd0, 64'd0, 8'd0, 5'd0}});
      rows.push_back('{64'd0, 64'h8000_0000_0000_0000, 1'b0, '{64'd0, 64'd0, 8'd0, 5'd0}});
      rows.push_back('{64'd256, 64'd0, 1'b0, '{64'd0, 64'd0, 8'd0, 5'd0}});
      rows.push_back('{{4{16'hAAAA}}, {4{16'hAAAA}}, 1'b0, '{64'd0, 64'd0, 8'd0, 5'd0}});
      rows.push_back('{{4{16'h5555}}, {4{16'h5555}}, 1'b0, '{64'd0, 64'd0, 8'd0, 5'd0}});
      rows.push_back('{64'(pow255(8)), 64'(pow255(8) >> 64), 1'b0,
                       '{64'd0, 64'd0, 8'd0, 5'd0}});
      rows.push_back('{64'(pow255(15)), 64'(pow255(15) >> 64), 1'b0,
                       '{64'd0, 64'd0, 8'd0, 5'd0}});

      clock              = 1'b0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_value_low      = 64'd0;
      req_value_high     = 64'd0;
      rsp_stall          = 1'b0;
      fail_count         = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].typed) begin
            directed_want = base255_digits(rows[i].value_low, rows[i].value_high);
            if (directed_want != rows[i].want) begin
               $display("%0t: table row %0d disagrees with predictor: expected %p, actual %p",
                        $time, i, rows[i].want, directed_want);
               fail_count++;
            end
         end
         send_value({rows[i].value_high, rows[i].value_low});
      end
      wait_all_returned();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
            default: begin sender_idle_pct = 18; receiver_stall_pct = 18; end
         endcase
         repeat (PHASE_ITEMS)
            send_value(random_value());
         wait_all_returned();
      end

      // catch any stray item after the last expected one
      repeat (3 * LATENCY) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/nbd_pkg.sv
rtl/core/nbd_cell.sv
rtl/core/nbd_collect.sv
rtl/core/number_to_base255_digits.sv
tb/tb_number_to_base255_digits.sv
